// File: rtl/text_console_writer_macros.svh
// Assertion macros for the text console writer checker.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcw_checker: property failed");

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcw_checker: property failed");

`endif

// File: rtl/tcw_pkg.sv
// Shared types, constants and codes for the text console writer.
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    // Field widths of the port words
    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int IN_ROW_W  = 5;
    localparam int IN_COL_W  = 7;
    localparam int POS_OUT_W = 11;
    localparam int CELL_W    = CHAR_W + ATTR_W;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 1'd1;
    localparam logic [CFG_DATA_W-1:0]  FG_RESET       = 4'd7;
    localparam logic [CFG_DATA_W-1:0]  BG_RESET       = 4'd0;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    // Character and attribute constants
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_LINEFEED  = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h00;
    localparam logic [ATTR_W-1:0] ATTR_DEFAULT = 8'h07;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [CHAR_W-1:0]   char_code;
        logic [IN_ROW_W-1:0] row;
        logic [IN_COL_W-1:0] col;
    } item_t;

    typedef struct packed {
        logic [POS_OUT_W-1:0] cursor_position;
        logic [IN_ROW_W-1:0]  cursor_row;
        logic [IN_COL_W-1:0]  cursor_col;
        logic [CHAR_W-1:0]    cell_char;
        logic [ATTR_W-1:0]    cell_attr;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take;        // latch the incoming word
        logic exec;        // apply the command to cursor / address
        logic init_wr;     // reset clearing pass
        logic copy;        // scroll: read one cell of the copy walk
        logic fill_start;  // scroll: point the walk at the bottom row
        logic fill_wr;     // scroll: blank one bottom-row cell
        logic clear_wr;    // clear: write one cell
        logic pos_upd;     // recompute linear cursor position
        logic load_out;    // load the result register
    } tcw_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             row_over;
        logic             walk_last;
    } tcw_sts_t;

endpackage
`default_nettype wire

// File: rtl/tcw_ctrl.sv
// Controller state machine for the text console writer.
`timescale 1ns / 1ps
`default_nettype none
module tcw_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output tcw_pkg::tcw_cmd_t     cmd,
    input  wire tcw_pkg::tcw_sts_t sts
);
    import tcw_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCROLL,
        S_DRAIN,
        S_FILL,
        S_CLEAR,
        S_POS,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free     = !out_valid_reg || !result_stall;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (sts.walk_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                case (sts.command)
                    CMD_PUT:   state_next = sts.row_over ? S_SCROLL : S_POS;
                    CMD_SET:   state_next = S_POS;
                    CMD_READ:  state_next = S_READ;
                    CMD_CLEAR: state_next = S_CLEAR;
                    default:   state_next = S_POS;
                endcase
            end
            S_READ:
                state_next = S_DONE;
            S_SCROLL:
            begin
                cmd.copy = 1'b1;
                if (sts.walk_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                // last copied cell is written here
                cmd.fill_start = 1'b1;
                state_next     = S_FILL;
            end
            S_FILL:
            begin
                cmd.fill_wr = 1'b1;
                if (sts.walk_last)
                    state_next = S_POS;
            end
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.walk_last)
                    state_next = S_POS;
            end
            S_POS:
            begin
                cmd.pos_upd = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Result valid: set on load, cleared when the word is taken
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/tcw_dp.sv
// Datapath for the text console writer: screen memory, cursor, walk counter.
`timescale 1ns / 1ps
`default_nettype none
module tcw_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tcw_pkg::item_t                 item,
    output tcw_pkg::result_t                    result,
    input  wire logic                           cfg_write,
    input  wire logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire tcw_pkg::tcw_cmd_t              cmd,
    output tcw_pkg::tcw_sts_t                   sts
);
    import tcw_pkg::*;

    localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);

    // Screen memory: char in the high byte, attribute in the low byte
    logic [CELL_W-1:0] screen_mem [CELLS];

    logic [ROW_W-1:0]      row_reg, row_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ADDR_W-1:0]     pos_reg, pos_next;
    logic [CFG_DATA_W-1:0] fg_reg, fg_next;
    logic [CFG_DATA_W-1:0] bg_reg, bg_next;
    logic [ADDR_W-1:0]     cnt_reg, cnt_next;
    logic                  cp_valid_reg;
    logic [ADDR_W-1:0]     cp_addr_reg;
    logic [ADDR_W-1:0]     rd_addr_reg, rd_addr_next;
    logic [CELL_W-1:0]     rdata_reg;
    item_t                 item_reg, item_next;
    result_t               out_reg, out_next;

    logic [ATTR_W-1:0] attr;
    logic              is_put, is_cr, is_lf, is_glyph;
    logic              col_last, row_last, advance_row;
    logic [ROW_W-1:0]  sat_row;
    logic [COL_W-1:0]  sat_col;
    logic              walking;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    // Decode of the held word
    assign attr        = {bg_reg, fg_reg};
    assign is_put      = (item_reg.command == CMD_PUT);
    assign is_cr       = (item_reg.char_code == CH_RETURN);
    assign is_lf       = (item_reg.char_code == CH_LINEFEED);
    assign is_glyph    = is_put && !is_cr && !is_lf;
    assign col_last    = (col_reg == LAST_COL);
    assign row_last    = (row_reg == LAST_ROW);
    assign advance_row = is_lf || (is_glyph && col_last);
    assign sat_row     = (int'(item_reg.row) >= ROWS) ? LAST_ROW : ROW_W'(item_reg.row);
    assign sat_col     = (int'(item_reg.col) >= COLUMNS) ? LAST_COL : COL_W'(item_reg.col);
    assign walking     = cmd.init_wr || cmd.copy || cmd.fill_wr || cmd.clear_wr;

    assign sts.command   = item_reg.command;
    assign sts.row_over  = is_put && advance_row && row_last;
    assign sts.walk_last = (cnt_reg == LAST_CELL);

    assign result = out_reg;

    // Configuration registers
    always_comb
    begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_FOREGROUND: fg_next = cfg_data;
                REG_BACKGROUND: bg_next = cfg_data;
                default:        fg_next = fg_reg;
            endcase
        end
    end

    // Cursor, read address and walk counter
    always_comb
    begin
        item_next    = cmd.take ? item : item_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        rd_addr_next = rd_addr_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;

        if (cmd.exec)
        begin
            cnt_next = (item_reg.command == CMD_CLEAR) ? '0 : COLS_A;
            case (item_reg.command)
                CMD_PUT:
                begin
                    if (is_cr || advance_row)
                        col_next = '0;
                    else
                        col_next = col_reg + COL_W'(1);
                    if (advance_row && !row_last)
                        row_next = row_reg + ROW_W'(1);
                end
                CMD_SET:
                begin
                    row_next = sat_row;
                    col_next = sat_col;
                end
                CMD_READ:
                    rd_addr_next = ADDR_W'(sat_row) * COLS_A + ADDR_W'(sat_col);
                CMD_CLEAR:
                begin
                    row_next = '0;
                    col_next = '0;
                end
                default:
                    row_next = row_reg;
            endcase
        end
        else if (cmd.fill_start)
            cnt_next = BOTTOM_ROW;
        else if (walking)
            cnt_next = cnt_reg + ADDR_W'(1);

        if (cmd.pos_upd)
            pos_next = ADDR_W'(row_reg) * COLS_A + ADDR_W'(col_reg);
    end

    // Memory port selection; a pending scroll copy owns the write port
    always_comb
    begin
        mem_we    = 1'b1;
        mem_waddr = cnt_reg;
        mem_wdata = {CH_BLANK, ATTR_DEFAULT};
        if (cp_valid_reg)
        begin
            mem_waddr = cp_addr_reg;
            mem_wdata = rdata_reg;
        end
        else if (cmd.init_wr)
            mem_wdata = {CH_BLANK, ATTR_DEFAULT};
        else if (cmd.fill_wr)
            mem_wdata = {CH_SPACE, ATTR_DEFAULT};
        else if (cmd.clear_wr)
            mem_wdata = {CH_BLANK, attr};
        else if (cmd.exec && is_glyph)
        begin
            mem_waddr = pos_reg;
            mem_wdata = {item_reg.char_code, attr};
        end
        else
            mem_we = 1'b0;
        mem_raddr = cmd.copy ? cnt_reg : rd_addr_reg;
    end

    // Result word
    always_comb
    begin
        out_next = out_reg;
        if (cmd.load_out)
        begin
            out_next.cursor_position = POS_OUT_W'(pos_reg);
            out_next.cursor_row      = IN_ROW_W'(row_reg);
            out_next.cursor_col      = IN_COL_W'(col_reg);
            if (item_reg.command == CMD_READ)
            begin
                out_next.cell_char = rdata_reg[CELL_W-1:ATTR_W];
                out_next.cell_attr = rdata_reg[ATTR_W-1:0];
            end
            else
            begin
                out_next.cell_char = '0;
                out_next.cell_attr = '0;
            end
        end
    end

    // Screen memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            screen_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= screen_mem[mem_raddr];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        rd_addr_reg <= rd_addr_next;
        cp_addr_reg <= cnt_reg - COLS_A;
        out_reg     <= out_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            pos_reg      <= '0;
            fg_reg       <= FG_RESET;
            bg_reg       <= BG_RESET;
            cnt_reg      <= '0;
            cp_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            pos_reg      <= pos_next;
            fg_reg       <= fg_next;
            bg_reg       <= bg_next;
            cnt_reg      <= cnt_next;
            cp_valid_reg <= cmd.copy;
        end
    end

endmodule
`default_nettype wire

// File: rtl/text_console_writer.sv
// Text console writer: top level joining the controller and the datapath.
// A text-mode console engine with an 80x25 screen of char/attribute cells
// held in one single-port-write, registered-read memory. After reset the
// block runs a clearing pass (one cell per cycle) before it takes its first
// word; configuration writes are taken throughout. Put character, set
// cursor and read cell pass from acceptance through an execute state and a
// cursor-position or read state to the done state, where the result is
// loaded; the next word is accepted only after that. A put character that
// moves past the last row scrolls the screen: the memory is walked one cell
// per cycle (1920 copies, a drain state, 80 bottom-row fills) before the
// cursor-position and done states. Clear screen writes all 2000 cells before
// the cursor-position and done states.
// One word is in work at a time; the result register lets a new word be
// accepted while the previous result waits, and a word that finishes while
// that result is still stalled waits in its final state for as long.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire tcw_pkg::item_t                  item,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output tcw_pkg::result_t                     result,
    input  wire logic                            cfg_write,
    input  wire logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tcw_pkg::*;

    tcw_cmd_t cmd;
    tcw_sts_t sts;

    // Sequencer
    tcw_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

    // Screen, cursor and result datapath
    tcw_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire

// File: rtl/tcw_checker.sv
// Port-level checker for the text console writer and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_macros.svh"
module tcw_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_valid,
    input wire logic             item_stall,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire tcw_pkg::result_t result
);
    import tcw_pkg::*;

    logic row_on_screen;
    logic col_on_screen;

    assign row_on_screen = (int'(result.cursor_row) < ROWS);
    assign col_on_screen = (int'(result.cursor_col) < COLUMNS);

    // A stalled result word stays valid
    `TCW_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)

    // A stalled result word keeps its value
    `TCW_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(result))

    // One word at a time: the block is busy right after taking one
    `TCW_ASSERT_NEXT(a_busy_after_take, item_valid && !item_stall, item_stall)

    // Reported cursor stays on the screen
    `TCW_ASSERT_SAME(a_cursor_on_screen, result_valid, row_on_screen && col_on_screen)

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
`default_nettype wire
